>>> hdl/psl_pkg.sv
`timescale 1ns / 1ps

package psl_pkg;

  // field and counter widths
  localparam int LIMIT_W       = 9;
  localparam int CNT_W         = LIMIT_W + 1;
  localparam int MAX_LIMIT_DEF = 256;
  localparam int FIRST_PRIME   = 2;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PTEST,
    ST_PFLAG,
    ST_MARK,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_lim;
    logic clr_init;
    logic clr_step;
    logic p_init;
    logic p_next;
    logic rd_p;
    logic mark_init;
    logic mark_step;
    logic scan_init;
    logic scan_step;
    logic push_last;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic lim_lt2;
    logic psq_gt_lim;
    logic flag;
    logic m_gt_lim;
    logic i_gt_lim;
    logic data_vld;
    logic out_free;
    logic pend_vld;
  } stat_t;

endpackage

>>> hdl/prime_sieve_lister_top.sv
// operation: every flag store entry up to MAX_LIMIT is first set to one, then each base p
// with p*p <= limit is tested, prime bases have multiples marked, numbers 2..limit are scanned
// throughput: one request at a time; the flag store is walked one entry per cycle, and
// scanning stalls while results wait
// reset: synchronous active-low rst_n clears the controller and valid flags; the flag
// store is not cleared by reset but is rewritten at the start of every request
`timescale 1ns / 1ps

module prime_sieve_lister_top #(
  parameter int MAX_LIMIT = psl_pkg::MAX_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [psl_pkg::LIMIT_W-1:0]  in_limit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psl_pkg::LIMIT_W-1:0]  out_prime_value,
  output logic                         out_last
);
  import psl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  psl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, flag store and output register
  psl_dp #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_limit        (in_limit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_prime_value (out_prime_value),
    .out_last        (out_last)
  );

endmodule

>>> hdl/psl_dp.sv
`timescale 1ns / 1ps

module psl_dp #(
  parameter int MAX_LIMIT = psl_pkg::MAX_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psl_pkg::cmd_t                cmd,
  output psl_pkg::stat_t               stat,
  input  logic [psl_pkg::LIMIT_W-1:0]  in_limit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [psl_pkg::LIMIT_W-1:0]  out_prime_value,
  output logic                         out_last
);
  import psl_pkg::*;

  localparam int DEPTH = MAX_LIMIT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [LIMIT_W-1:0] MAX_L = LIMIT_W'(MAX_LIMIT);

  logic [LIMIT_W-1:0] lim_r;
  logic [CNT_W-1:0]   m_r;
  logic [LIMIT_W-1:0] p_r;
  logic [CNT_W-1:0]   psq_r;
  logic [CNT_W-1:0]   i_r;
  logic               dv_r;
  logic               flag_r;
  logic [LIMIT_W-1:0] pend_r;
  logic               pend_vld_r;
  logic               out_valid_r;
  logic [LIMIT_W-1:0] out_prime_r;
  logic               out_last_r;

  logic               mem [DEPTH];
  logic               wr_en;
  logic               wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               i_le_lim;
  logic               found;
  logic               out_load;
  logic               out_free;
  logic [CNT_W-1:0]   lim_ext;
  logic [CNT_W-1:0]   p_ext;

  assign lim_ext  = {1'b0, lim_r};
  assign p_ext    = {1'b0, p_r};
  assign i_le_lim = (i_r <= lim_ext);
  assign out_free = !out_valid_r || out_ready;

  // flag store ports
  assign wr_en   = cmd.clr_step || cmd.mark_step;
  assign wr_data = cmd.clr_step;
  assign rd_en   = cmd.rd_p || (cmd.scan_step && i_le_lim);
  assign rd_addr = cmd.rd_p ? p_r[AW-1:0] : i_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[m_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      flag_r <= mem[rd_addr];
    end
  end

  // limit, sweep and marking counters
  always_ff @(posedge clk) begin
    if (cmd.load_lim) begin
      lim_r <= (in_limit > MAX_L) ? MAX_L : in_limit;
    end
    if (cmd.clr_init) begin
      m_r <= '0;
    end else if (cmd.clr_step) begin
      m_r <= m_r + CNT_W'(1);
    end else if (cmd.mark_init) begin
      m_r <= psq_r;
    end else if (cmd.mark_step) begin
      m_r <= m_r + p_ext;
    end
    // square tracked incrementally: (p+1)^2 = p^2 + 2p + 1
    if (cmd.p_init) begin
      p_r   <= LIMIT_W'(FIRST_PRIME);
      psq_r <= CNT_W'(FIRST_PRIME * FIRST_PRIME);
    end else if (cmd.p_next) begin
      p_r   <= p_r + LIMIT_W'(1);
      psq_r <= psq_r + {p_ext[CNT_W-2:0], 1'b1};
    end
  end

  // scan index and read-data valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else if (cmd.scan_init) begin
      dv_r <= 1'b0;
    end else if (cmd.scan_step) begin
      dv_r <= i_le_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      i_r <= CNT_W'(FIRST_PRIME);
    end else if (cmd.scan_step) begin
      i_r <= i_r + CNT_W'(1);
    end
  end

  // one-deep pending prime so the largest one can carry last
  assign found    = cmd.scan_step && dv_r && flag_r;
  assign out_load = (found && pend_vld_r) || cmd.push_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (found) begin
      pend_vld_r <= 1'b1;
    end else if (cmd.push_last || cmd.scan_init) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (found) begin
      pend_r <= LIMIT_W'(i_r - CNT_W'(1));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_prime_r <= pend_r;
      out_last_r  <= cmd.push_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_prime_r;
  assign out_last        = out_last_r;

  // status back to the controller
  always_comb begin
    stat.clr_done   = (m_r == CNT_W'(MAX_LIMIT));
    stat.lim_lt2    = (lim_r < LIMIT_W'(FIRST_PRIME));
    stat.psq_gt_lim = (psq_r > lim_ext);
    stat.flag       = flag_r;
    stat.m_gt_lim   = (m_r > lim_ext);
    stat.i_gt_lim   = !i_le_lim;
    stat.data_vld   = dv_r;
    stat.out_free   = out_free;
    stat.pend_vld   = pend_vld_r;
  end

endmodule

>>> hdl/psl_ctrl.sv
`timescale 1ns / 1ps

module psl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  psl_pkg::stat_t stat,
  output psl_pkg::cmd_t  cmd
);
  import psl_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_lim = 1'b1;
          cmd.clr_init = 1'b1;
          state_nxt    = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          cmd.p_init = 1'b1;
          state_nxt  = ST_PTEST;
        end
      end
      ST_PTEST: begin
        if (stat.psq_gt_lim) begin
          if (stat.lim_lt2) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end else begin
          cmd.rd_p  = 1'b1;
          state_nxt = ST_PFLAG;
        end
      end
      ST_PFLAG: begin
        if (stat.flag) begin
          cmd.mark_init = 1'b1;
          state_nxt     = ST_MARK;
        end else begin
          cmd.p_next = 1'b1;
          state_nxt  = ST_PTEST;
        end
      end
      ST_MARK: begin
        if (stat.m_gt_lim) begin
          cmd.p_next = 1'b1;
          state_nxt  = ST_PTEST;
        end else begin
          cmd.mark_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (stat.i_gt_lim && !stat.data_vld) begin
          state_nxt = ST_FLUSH;
        end else if (stat.out_free) begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_vld) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
